### rtl/sem_pkg.sv
package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int RING_DEPTH = 2 * MAX_WIDTH + 3;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = 11;
  localparam int HGT_W      = 16;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 16;
  localparam int PIX_W      = 24;
  localparam int ACC_W      = 12;
  localparam int NUM_TAPS   = 9;

  localparam logic [CFG_AW-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [7:0]  EDGE_MAX  = 8'd255;
  localparam logic [21:0] SAT_LIMIT = 22'd65280;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // row offset of a tap: -1, 0, +1
  function automatic logic signed [1:0] tap_dr(input logic [3:0] tap);
    logic signed [1:0] r;
    unique case (tap)
      4'd0, 4'd1, 4'd2: r = -2'sd1;
      4'd3, 4'd4, 4'd5: r = 2'sd0;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] tap_dc(input logic [3:0] tap);
    logic signed [1:0] r;
    unique case (tap)
      4'd0, 4'd3, 4'd6: r = -2'sd1;
      4'd1, 4'd4, 4'd7: r = 2'sd0;
      default:          r = 2'sd1;
    endcase
    return r;
  endfunction

  // multiply a pixel value by a weight in -2..2
  function automatic acc_t scale(input logic signed [2:0] wgt, input logic [7:0] v);
    acc_t x;
    acc_t r;
    x = acc_t'({4'b0, v});
    unique case (wgt)
      3'sd2:   r = x <<< 1;
      3'sd1:   r = x;
      -3'sd1:  r = -x;
      -3'sd2:  r = -(x <<< 1);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [2:0] tap_wx(input logic [3:0] tap);
    logic signed [2:0] dc;
    dc = 3'(tap_dc(tap));
    return (tap_dr(tap) == 2'sd0) ? (dc <<< 1) : dc;
  endfunction

  function automatic logic signed [2:0] tap_wy(input logic [3:0] tap);
    logic signed [2:0] dr;
    dr = 3'(tap_dr(tap));
    return (tap_dc(tap) == 2'sd0) ? (dr <<< 1) : dr;
  endfunction

endpackage

### rtl/sem_if.sv
interface sem_in_if;
  import sem_pkg::*;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, cmd, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, cmd, red_in, green_in, blue_in, output ready);
endinterface

interface sem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_edge;
  logic [7:0] green_edge;
  logic [7:0] blue_edge;
  logic       frame_end;
  modport source (output valid, red_edge, green_edge, blue_edge, frame_end, input ready);
  modport sink   (input valid, red_edge, green_edge, blue_edge, frame_end, output ready);
endinterface

interface sem_cfg_if;
  import sem_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

### rtl/sem_ram.sv
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sobel_edge_magnitude_rgb.sv
// 3x3 Sobel edge magnitude over an RGB pixel stream.
// in_ch carries raster-order pixels (cmd 0) or drain items (cmd 1); out_ch
// carries the per-channel magnitudes and frame_end on the frame's last result.
// cfg_ch writes frame_width (addr 0) and frame_height (addr 1); a write
// restarts the frame. Write only while the block is idle.
// The result for a pixel follows frame_width + 1 items after it; the last
// frame_width + 1 results are pulled out with drain items.
// An item that yields a result holds the input through nine reads of the
// ring memory (one write and one read port, one tap a cycle), squaring one
// channel at a time through one multiplier pair, and eight steps of the
// digit-by-digit square root, run for all three channels side by side.
// A finished result sits in the output register; the next item is taken
// while it waits, and the block holds before loading a new result until
// the receiver takes the old one.
// Reset (synchronous, active low) sets width and height to 1024 and clears
// the frame position. The ring memory needs no clearing: entries are
// always written before they are read.
module sobel_edge_magnitude_rgb
  import sem_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  sem_in_if.sink   in_ch,
  sem_out_if.source out_ch,
  sem_cfg_if.sink  cfg_ch
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_SQ   = 5'b00100,
    S_ROOT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [WID_W-1:0]   width_r;
  logic [HGT_W-1:0]   height_r;
  logic [COL_W-1:0]   in_col_r, out_col_r;
  logic [HGT_W-1:0]   in_row_r, out_row_r;
  logic [RING_AW-1:0] in_ptr_r, out_ptr_r;
  logic [WID_W-1:0]   diff_r;

  logic [3:0]  tap_r;
  logic        d_vld_r;
  logic [3:0]  d_tap_r;
  acc_t        gx_r [3];
  acc_t        gy_r [3];
  logic [1:0]  sq_ch_r;
  logic        sat_r [3];
  logic [16:0] rem_r [3];
  logic [15:0] root_r[3];
  logic [2:0]  step_r;

  logic       out_valid_r;
  logic [7:0] out_edge_r [3];
  logic       out_end_r;

  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  always_comb begin
    if (width_r == '0) w_eff = WID_W'(1);
    else if (width_r > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
    else w_eff = width_r;
    h_eff = (height_r == '0) ? HGT_W'(1) : height_r;
  end

  logic in_fire, cfg_fire, cfg_hit, input_done, pix_take, emit;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire  = in_ch.valid & in_ch.ready;
  assign cfg_fire = cfg_ch.valid & cfg_ch.ready;
  assign cfg_hit  = cfg_fire &&
                    (cfg_ch.addr == CFG_FRAME_WIDTH || cfg_ch.addr == CFG_FRAME_HEIGHT);
  assign input_done = (in_row_r >= h_eff);
  assign pix_take   = in_fire && (in_ch.cmd == CMD_PIXEL) && !input_done;
  assign emit = pix_take ? ((WID_W+1)'(diff_r) + 1'b1 > (WID_W+1)'(w_eff) + 1'b1)
                         : (in_fire && input_done);

  // tap address and bounds
  logic signed [1:0] dr, dc;
  logic              tap_inb;
  logic signed [RING_AW+1:0] addr_s;
  logic [RING_AW-1:0] raddr;
  pixel_t rdata;
  always_comb begin
    logic signed [RING_AW+1:0] offs;
    dr = tap_dr(tap_r);
    dc = tap_dc(tap_r);
    tap_inb = 1'b1;
    if (dr == -2'sd1 && out_row_r == '0) tap_inb = 1'b0;
    if (dr == 2'sd1 && (17'(out_row_r) + 1'b1 >= 17'(h_eff))) tap_inb = 1'b0;
    if (dc == -2'sd1 && out_col_r == '0) tap_inb = 1'b0;
    if (dc == 2'sd1 && ((WID_W)'(out_col_r) + 1'b1 >= w_eff)) tap_inb = 1'b0;
    unique case (dr)
      -2'sd1:  offs = -$signed({2'b00, w_eff});
      2'sd1:   offs = $signed({2'b00, w_eff});
      default: offs = '0;
    endcase
    offs = offs + (RING_AW+2)'(dc);
    addr_s = $signed({2'b00, out_ptr_r}) + offs;
    if (addr_s < 0) addr_s = addr_s + (RING_AW+2)'(RING_DEPTH);
    else if (addr_s >= (RING_AW+2)'(RING_DEPTH)) addr_s = addr_s - (RING_AW+2)'(RING_DEPTH);
    raddr = addr_s[RING_AW-1:0];
  end

  sem_ram #(.WIDTH(PIX_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (pix_take),
    .waddr (in_ptr_r),
    .wdata ({in_ch.blue_in, in_ch.green_in, in_ch.red_in}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // square of the selected channel
  logic signed [2*ACC_W-1:0] sqx, sqy;
  logic [21:0] ssum;
  always_comb begin
    sqx  = gx_r[sq_ch_r] * gx_r[sq_ch_r];
    sqy  = gy_r[sq_ch_r] * gy_r[sq_ch_r];
    ssum = 22'(sqx[20:0]) + 22'(sqy[20:0]);
  end

  logic [15:0] bit_v;
  assign bit_v = 16'h4000 >> {step_r, 1'b0};

  logic [7:0] edge_v [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [16:0] q;
      q = 17'(root_r[c]) + 17'(rem_r[c] > 17'(root_r[c]));
      edge_v[c] = (sat_r[c] || q > 17'(EDGE_MAX)) ? EDGE_MAX : q[7:0];
    end
  end

  logic last_out, out_free;
  assign last_out = (out_row_r == h_eff - 1'b1) && (WID_W'(out_col_r) == w_eff - 1'b1);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (emit) state_nxt = S_READ;
      S_READ: if (tap_r == 4'(NUM_TAPS)) state_nxt = S_SQ;
      S_SQ:   if (sq_ch_r == 2'd2) state_nxt = S_ROOT;
      S_ROOT: if (step_r == 3'd7) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= WID_W'(1024);
      height_r    <= HGT_W'(1024);
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      in_ptr_r    <= '0;
      out_ptr_r   <= '0;
      diff_r      <= '0;
      out_valid_r <= 1'b0;
      d_vld_r     <= 1'b0;
      tap_r       <= '0;
      sq_ch_r     <= '0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      if (cfg_fire && cfg_ch.addr == CFG_FRAME_WIDTH) width_r <= cfg_ch.data[WID_W-1:0];
      if (cfg_fire && cfg_ch.addr == CFG_FRAME_HEIGHT) height_r <= cfg_ch.data;

      if (pix_take) begin
        diff_r   <= diff_r + 1'b1;
        in_ptr_r <= (in_ptr_r == RING_AW'(RING_DEPTH - 1)) ? '0 : in_ptr_r + 1'b1;
        if (WID_W'(in_col_r) + 1'b1 >= w_eff) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + 1'b1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
      end

      if (state_r == S_IDLE) begin
        tap_r   <= '0;
        d_vld_r <= 1'b0;
        sq_ch_r <= '0;
        step_r  <= '0;
        for (int c = 0; c < 3; c++) begin
          gx_r[c] <= '0;
          gy_r[c] <= '0;
        end
      end

      if (state_r == S_READ) begin
        d_vld_r <= (tap_r < 4'(NUM_TAPS)) && tap_inb;
        d_tap_r <= tap_r;
        if (tap_r < 4'(NUM_TAPS)) tap_r <= tap_r + 1'b1;
        if (d_vld_r) begin
          for (int c = 0; c < 3; c++) begin
            gx_r[c] <= gx_r[c] + scale(tap_wx(d_tap_r), rdata[8*c +: 8]);
            gy_r[c] <= gy_r[c] + scale(tap_wy(d_tap_r), rdata[8*c +: 8]);
          end
        end
      end

      if (state_r == S_SQ) begin
        sat_r[sq_ch_r]  <= ssum > SAT_LIMIT;
        rem_r[sq_ch_r]  <= 17'(ssum[15:0]);
        root_r[sq_ch_r] <= '0;
        sq_ch_r <= sq_ch_r + 1'b1;
      end

      if (state_r == S_ROOT) begin
        step_r <= step_r + 1'b1;
        for (int c = 0; c < 3; c++) begin
          if (rem_r[c] >= 17'(root_r[c]) + 17'(bit_v)) begin
            rem_r[c]  <= rem_r[c] - 17'(root_r[c]) - 17'(bit_v);
            root_r[c] <= (root_r[c] >> 1) + bit_v;
          end else begin
            root_r[c] <= root_r[c] >> 1;
          end
        end
      end

      if (state_r == S_DONE && out_free) begin
        for (int c = 0; c < 3; c++) out_edge_r[c] <= edge_v[c];
        out_end_r <= last_out;
        if (last_out) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
          in_ptr_r  <= '0;
          out_ptr_r <= '0;
          diff_r    <= '0;
        end else begin
          diff_r    <= diff_r - 1'b1;
          out_ptr_r <= (out_ptr_r == RING_AW'(RING_DEPTH - 1)) ? '0 : out_ptr_r + 1'b1;
          if (WID_W'(out_col_r) + 1'b1 >= w_eff) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + 1'b1;
          end else begin
            out_col_r <= out_col_r + 1'b1;
          end
        end
      end

      if (cfg_hit) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        in_ptr_r  <= '0;
        out_ptr_r <= '0;
        diff_r    <= '0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.red_edge   = out_edge_r[0];
  assign out_ch.green_edge = out_edge_r[1];
  assign out_ch.blue_edge  = out_edge_r[2];
  assign out_ch.frame_end  = out_end_r;

  logic unused_s;
  assign unused_s = ^{addr_s[RING_AW+1:RING_AW]};

endmodule

### rtl/sem_chk.sv
module sem_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic       out_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_end))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after a transfer");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result loaded while input open");

endmodule

bind sobel_edge_magnitude_rgb sem_chk u_sem_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_red   (out_ch.red_edge),
  .out_end   (out_ch.frame_end)
);

### tb/tb_sobel_edge_magnitude_rgb.sv
module tb_sobel_edge_magnitude_rgb;
  import sem_pkg::*;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } edge_t;

  localparam int IDLE_LIMIT   = 5000;
  localparam int SETTLE_ALLOW = 60;

  logic clk;
  logic rst_n;

  sem_in_if  in_ch ();
  sem_out_if out_ch ();
  sem_cfg_if cfg_ch ();

  sobel_edge_magnitude_rgb i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  edge_t  expected_edges[$];
  pixel_t pixel_ring[RING_DEPTH];
  int unsigned width_reg, height_reg;
  int unsigned rx_col, rx_row, tx_col, tx_row;
  int  errors;
  int  items_sent;
  int  hold_cycles;
  bit  no_idle;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned used_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned used_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic logic [7:0] edge_magnitude(input int gx, input int gy);
    int s;
    int q;
    s = gx * gx + gy * gy;
    if (s > int'(SAT_LIMIT)) return EDGE_MAX;
    q = 0;
    while ((q + 1) * (q + 1) <= s) q++;
    if (s > q * q + q) q++;
    return (q > 255) ? EDGE_MAX : 8'(q);
  endfunction

  // advance the frame model by one transfer; returns 1 when a result is due
  function automatic bit predict_edges(input logic cmd, input pixel_t pix, output edge_t e);
    int unsigned w, h, total, rcv, sent;
    int gx[3], gy[3];
    int r, c, wx, wy, v;
    bit done, due;
    w = used_width();
    h = used_height();
    total = w * h;
    done = (rx_row >= h);
    due = 1'b0;
    e = '{default: '0};
    for (int ch = 0; ch < 3; ch++) begin
      gx[ch] = 0;
      gy[ch] = 0;
    end
    if (cmd == CMD_PIXEL && !done) begin
      pixel_ring[(rx_row * w + rx_col) % RING_DEPTH] = pix;
      rx_col++;
      if (rx_col >= w) begin
        rx_col = 0;
        rx_row++;
      end
      rcv = rx_row * w + rx_col;
      sent = tx_row * w + tx_col;
      due = (rcv - sent > w + 1);
    end else if (done) begin
      due = 1'b1;
    end
    if (!due) return 1'b0;
    for (int dr = -1; dr <= 1; dr++) begin
      r = int'(tx_row) + dr;
      if (r < 0 || r >= int'(h)) continue;
      for (int dc = -1; dc <= 1; dc++) begin
        c = int'(tx_col) + dc;
        if (c < 0 || c >= int'(w)) continue;
        wx = dc * ((dr == 0) ? 2 : 1);
        wy = dr * ((dc == 0) ? 2 : 1);
        for (int ch = 0; ch < 3; ch++) begin
          v = int'(pixel_ring[(r * w + c) % RING_DEPTH][8*ch +: 8]);
          gx[ch] += wx * v;
          gy[ch] += wy * v;
        end
      end
    end
    e.red   = edge_magnitude(gx[0], gy[0]);
    e.green = edge_magnitude(gx[1], gy[1]);
    e.blue  = edge_magnitude(gx[2], gy[2]);
    if (tx_row * w + tx_col + 1 >= total) begin
      e.frame_end = 1'b1;
      rx_col = 0;
      rx_row = 0;
      tx_col = 0;
      tx_row = 0;
    end else begin
      tx_col++;
      if (tx_col >= w) begin
        tx_col = 0;
        tx_row++;
      end
    end
    return 1'b1;
  endfunction

  task automatic send_item(input logic cmd, input pixel_t pix);
    int gap;
    edge_t e;
    gap = rand_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.red_in   <= pix[7:0];
    in_ch.green_in <= pix[15:8];
    in_ch.blue_in  <= pix[23:16];
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (predict_edges(cmd, pix, e)) expected_edges.push_back(e);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_ALLOW) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= addr;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (addr == CFG_FRAME_WIDTH) width_reg = data & 16'h07FF;
    else height_reg = data;
    rx_col = 0;
    rx_row = 0;
    tx_col = 0;
    tx_row = 0;
  endtask

  task automatic set_frame(input int w, input int h);
    settle();
    write_reg(CFG_FRAME_WIDTH, CFG_DW'(w));
    write_reg(CFG_FRAME_HEIGHT, CFG_DW'(h));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic pixel_t rand_pixel();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 8'($urandom), 8'($urandom)};
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // pixels of the current frame, then the tail flush
  task automatic send_frame(input int pixels, input bit noisy);
    int w;
    w = used_width();
    for (int i = 0; i < pixels; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_item(CMD_DRAIN, rand_pixel());
      send_item(CMD_PIXEL, rand_pixel());
    end
    for (int i = 0; i <= w; i++)
      send_item($urandom_range(0, 3) == 0 ? CMD_PIXEL : CMD_DRAIN, rand_pixel());
  endtask

  task automatic test_small_frames();
    set_frame(1, 1);
    send_item(CMD_PIXEL, 24'hFFFFFF);
    send_item(CMD_DRAIN, '0);
    send_item(CMD_DRAIN, '0);
    set_frame(0, 0);
    send_item(CMD_PIXEL, 24'h00FF80);
    send_item(CMD_PIXEL, 24'h123456);
    send_item(CMD_DRAIN, '0);
    set_frame(2, 1);
    send_frame(2, 0);
  endtask

  task automatic test_extremes();
    set_frame(3, 3);
    for (int i = 0; i < 9; i++)
      send_item(CMD_PIXEL, (i % 2 == 0) ? 24'hFFFFFF : 24'h000000);
    send_item(CMD_PIXEL, 24'hABCDEF);
    for (int i = 0; i < 3; i++) send_item(CMD_DRAIN, '0);
    set_frame(3, 2);
    send_item(CMD_PIXEL, 24'h00FF00);
    send_item(CMD_PIXEL, 24'hFF00FF);
    send_item(CMD_PIXEL, 24'h0000FF);
    send_item(CMD_PIXEL, 24'hFF0000);
    send_item(CMD_PIXEL, 24'h00FFFF);
    send_item(CMD_PIXEL, 24'hFFFF00);
    for (int i = 0; i < 4; i++) send_item(CMD_DRAIN, '0);
  endtask

  task automatic test_stray_items();
    set_frame(4, 2);
    send_item(CMD_DRAIN, '1);
    send_item(CMD_PIXEL, 24'h102030);
    send_item(CMD_DRAIN, '0);
    for (int i = 0; i < 7; i++) send_item(CMD_PIXEL, rand_pixel());
    for (int i = 0; i < 5; i++) send_item(CMD_PIXEL, '1);
    send_item(CMD_DRAIN, '0);
  endtask

  task automatic test_large_settings();
    set_frame(2047, 0);
    for (int i = 0; i < 20; i++) send_item(CMD_PIXEL, rand_pixel());
    set_frame(1, 65535);
    for (int i = 0; i < 10; i++) send_item(CMD_PIXEL, rand_pixel());
    set_frame(MAX_WIDTH, 3);
    for (int i = 0; i < 5; i++) send_item(CMD_PIXEL, rand_pixel());
  endtask

  task automatic test_backpressure();
    set_frame(6, 4);
    no_idle = 1'b1;
    hold_cycles = 400;
    send_frame(24, 0);
    no_idle = 1'b0;
    settle();
    send_frame(24, 1);
  endtask

  task automatic test_random_frames();
    int w, h, pixels;
    while (items_sent < 850) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      h = $urandom_range(0, 6);
      set_frame(w, h);
      no_idle = ($urandom_range(0, 4) == 0);
      pixels = used_width() * used_height();
      if ($urandom_range(0, 11) == 0) begin
        pixels = $urandom_range(0, pixels);
        for (int i = 0; i < pixels; i++) send_item(CMD_PIXEL, rand_pixel());
      end else begin
        send_frame(pixels, 1);
        if ($urandom_range(0, 5) == 0) send_item(CMD_DRAIN, rand_pixel());
      end
      no_idle = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    edge_t e;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_edges.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = expected_edges.pop_front();
        if (out_ch.red_edge !== e.red) begin
          $error("red_edge expected %0d actual %0d", e.red, out_ch.red_edge);
          errors++;
        end
        if (out_ch.green_edge !== e.green) begin
          $error("green_edge expected %0d actual %0d", e.green, out_ch.green_edge);
          errors++;
        end
        if (out_ch.blue_edge !== e.blue) begin
          $error("blue_edge expected %0d actual %0d", e.blue, out_ch.blue_edge);
          errors++;
        end
        if (out_ch.frame_end !== e.frame_end) begin
          $error("frame_end expected %0d actual %0d", e.frame_end, out_ch.frame_end);
          errors++;
        end
      end
    end
  end

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        gap = rand_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap - 1) @(posedge clk);
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    items_sent = 0;
    hold_cycles = 0;
    no_idle = 1'b0;
    width_reg = MAX_WIDTH;
    height_reg = 1024;
    rx_col = 0;
    rx_row = 0;
    tx_col = 0;
    tx_row = 0;
    for (int i = 0; i < RING_DEPTH; i++) pixel_ring[i] = '0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= CMD_PIXEL;
    in_ch.red_in   <= '0;
    in_ch.green_in <= '0;
    in_ch.blue_in  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.addr    <= CFG_FRAME_WIDTH;
    cfg_ch.data    <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_small_frames();
    test_extremes();
    test_stray_items();
    test_large_settings();
    test_backpressure();
    test_random_frames();
    settle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
